@@ rtl/radix_number_formatter_defines.svh @@
// ----------------------------------------------------------------------------
// radix_number_formatter_defines.svh
// Assertion macros used by the radix number formatter RTL.
// ----------------------------------------------------------------------------
`ifndef RADIX_NUMBER_FORMATTER_DEFINES_SVH
`define RADIX_NUMBER_FORMATTER_DEFINES_SVH

`ifndef SYNTHESIS
// Property checked on every clock edge outside reset.
`define RNF_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Antecedent in this cycle implies consequent in the next cycle.
`define RNF_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RNF_ASSERT(name, prop, msg)
`define RNF_ASSERT_NEXT(name, ante, cons, msg)
`endif

`endif

@@ rtl/rnf_pkg.sv @@
// ----------------------------------------------------------------------------
// rnf_pkg
// Shared constants and types of the radix number formatter.
// ----------------------------------------------------------------------------
package rnf_pkg;

  localparam int unsigned VALUE_WIDTH_DEFAULT = 64;
  localparam int unsigned MAX_RADIX_DEFAULT   = 16;

  localparam int unsigned IN_TDATA_W  = 64;  // value field
  localparam int unsigned OUT_TDATA_W = 16;  // out_char, char_count, pad
  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned COUNT_W     = 7;
  localparam int unsigned RADIX_W     = 5;
  localparam int unsigned DIGIT_W     = 4;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 64;

  localparam logic [CHAR_W-1:0]  MINUS_CHAR = 8'h2D;
  localparam logic [RADIX_W-1:0] BASE_RESET = 5'd10;
  localparam logic [RADIX_W-1:0] MIN_RADIX  = 5'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BASE_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHARS_LOW   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHARS_HIGH  = 2'd2;

  // Divider status toward the sequencer
  typedef struct packed {
    logic done;     // one-cycle pulse, digit and quotient valid
    logic nonzero;  // quotient of the finished step is not zero
  } div_status_t;

endpackage

@@ rtl/rnf_divider.sv @@
// ----------------------------------------------------------------------------
// rnf_divider
// Bit-serial restoring divider: one quotient bit per cycle, small remainder.
// ----------------------------------------------------------------------------
module rnf_divider import rnf_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [VALUE_WIDTH-1:0] operand_i,
  input  logic [RADIX_W-1:0]     radix_i,
  output logic [VALUE_WIDTH-1:0] quotient_o,
  output logic [DIGIT_W-1:0]     digit_o,
  output div_status_t            status_o
);

  localparam int unsigned CntW = $clog2(VALUE_WIDTH);

  logic [VALUE_WIDTH-1:0] quot_q, quot_d;
  logic [DIGIT_W-1:0]     rem_q, rem_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  logic                   nz_q, nz_d;

  logic [RADIX_W-1:0] trial;
  logic [RADIX_W-1:0] diff;
  logic               fits;

  // partial remainder with the next dividend bit shifted in
  assign trial = {rem_q, quot_q[VALUE_WIDTH-1]};
  assign diff  = trial - radix_i;
  assign fits  = (trial >= radix_i);

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    nz_d   = nz_q;
    done_d = 1'b0;
    if (start_i) begin
      quot_d = operand_i;
      rem_d  = '0;
      cnt_d  = CntW'(VALUE_WIDTH - 1);
      busy_d = 1'b1;
      nz_d   = 1'b0;
    end else if (busy_q) begin
      quot_d = {quot_q[VALUE_WIDTH-2:0], fits};
      rem_d  = fits ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
      nz_d   = nz_q | fits;
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    nz_q   <= nz_d;
  end

  assign quotient_o       = quot_q;
  assign digit_o          = rem_q;
  assign status_o.done    = done_q;
  assign status_o.nonzero = nz_q;

endmodule

@@ rtl/rnf_digit_ram.sv @@
// ----------------------------------------------------------------------------
// rnf_digit_ram
// Digit store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module rnf_digit_ram import rnf_pkg::*; #(
  parameter int unsigned DEPTH = VALUE_WIDTH_DEFAULT
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DIGIT_W-1:0]       wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DIGIT_W-1:0]       rdata_o
);

  logic [DIGIT_W-1:0] mem [DEPTH];
  logic [DIGIT_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/radix_number_formatter.sv @@
// ----------------------------------------------------------------------------
// radix_number_formatter
// Converts one integer per request into text in a programmable radix.
//
// Each input request carries a VALUE_WIDTH-bit value (low bits of tdata) and a
// signed flag (tuser). The block streams its text one character per output
// request, most significant digit first; a negative signed value is preceded
// by '-'. Digit symbols come from the 16-byte alphabet in digit_chars_low/high,
// the radix from base_length (clamped to 2..MAX_RADIX). The final character
// has tlast set and carries the total character count; the most negative
// signed value yields a single request with tuser (bad_value) set, char 0,
// count 0. Digits are produced least significant first by a bit-serial
// divider into a registered digit store, and each character is then read
// back from the store (S_FETCH, then S_SHOW) into the output register; a
// receiver that holds off a character stalls the sequencer.
// One number is converted at a time; a new request is taken as soon as the
// last character of the previous one sits in the output register.
// The user must write configuration through the cfg channel only while the
// block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`include "radix_number_formatter_defines.svh"

module radix_number_formatter import rnf_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEFAULT,
  parameter int unsigned MAX_RADIX   = MAX_RADIX_DEFAULT
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration write channel
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  // input stream
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,   // [63:0] value
  input  logic                   s_axis_tuser_i,   // [0] signed_mode
  // output stream
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,   // [7:0] out_char, [14:8] char_count
  output logic                   m_axis_tlast_o,   // last_char
  output logic                   m_axis_tuser_o    // [0] bad_value
);

  localparam int unsigned AddrW = $clog2(VALUE_WIDTH);
  localparam int unsigned CntW  = $clog2(VALUE_WIDTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_BAD,
    S_DIVIDE,
    S_SIGN,
    S_FETCH,
    S_SHOW
  } state_e;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [RADIX_W-1:0]    base_q;
  logic [CFG_DATA_W-1:0] chars_lo_q;
  logic [CFG_DATA_W-1:0] chars_hi_q;
  logic                  cfg_hs;

  assign cfg_ready_o = 1'b1;
  assign cfg_hs      = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q     <= BASE_RESET;
      chars_lo_q <= '0;
      chars_hi_q <= '0;
    end else if (cfg_hs) begin
      unique case (cfg_index_i)
        REG_BASE_LENGTH: base_q     <= cfg_data_i[RADIX_W-1:0];
        REG_CHARS_LOW:   chars_lo_q <= cfg_data_i;
        REG_CHARS_HIGH:  chars_hi_q <= cfg_data_i;
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // radix clamped to the supported range
  logic [RADIX_W-1:0] radix;
  always_comb begin
    if (base_q < MIN_RADIX) begin
      radix = MIN_RADIX;
    end else if (base_q > RADIX_W'(MAX_RADIX)) begin
      radix = RADIX_W'(MAX_RADIX);
    end else begin
      radix = base_q;
    end
  end

  // digit value to alphabet byte
  function automatic logic [CHAR_W-1:0] symbol_of(input logic [DIGIT_W-1:0] d,
                                                  input logic [CFG_DATA_W-1:0] lo,
                                                  input logic [CFG_DATA_W-1:0] hi);
    logic [CHAR_W-1:0] sym;
    if (!d[DIGIT_W-1]) begin
      sym = lo[CHAR_W*d[DIGIT_W-2:0] +: CHAR_W];
    end else begin
      sym = hi[CHAR_W*d[DIGIT_W-2:0] +: CHAR_W];
    end
    return sym;
  endfunction

  // --------------------------------------------------------------------------
  // Input decode
  // --------------------------------------------------------------------------
  logic [VALUE_WIDTH-1:0] in_value;
  logic [VALUE_WIDTH-1:0] in_mag;
  logic                   in_neg;
  logic                   in_bad;
  logic                   s_hs;

  assign s_hs     = s_axis_tvalid_i & s_axis_tready_o;
  assign in_value = s_axis_tdata_i[VALUE_WIDTH-1:0];
  assign in_neg   = s_axis_tuser_i & in_value[VALUE_WIDTH-1];
  // most negative value: sign bit alone
  assign in_bad   = in_neg & (in_value[VALUE_WIDTH-2:0] == '0);
  assign in_mag   = in_neg ? (~in_value + 1'b1) : in_value;

  // --------------------------------------------------------------------------
  // Divider and digit store
  // --------------------------------------------------------------------------
  logic                   div_start;
  logic [VALUE_WIDTH-1:0] div_operand;
  logic [VALUE_WIDTH-1:0] div_quot;
  logic [DIGIT_W-1:0]     div_digit;
  div_status_t            div_st;

  rnf_divider #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_divider (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .operand_i (div_operand),
    .radix_i   (radix),
    .quotient_o(div_quot),
    .digit_o   (div_digit),
    .status_o  (div_st)
  );

  state_e           state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d;    // digits stored so far
  logic [AddrW-1:0] idx_q, idx_d;    // digit being read out
  logic             neg_q, neg_d;

  logic               ram_we;
  logic               ram_re;
  logic [DIGIT_W-1:0] ram_rdata;

  assign ram_we = (state_q == S_DIVIDE) & div_st.done;
  assign ram_re = (state_q == S_FETCH);

  rnf_digit_ram #(
    .DEPTH(VALUE_WIDTH)
  ) u_digit_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(cnt_q[AddrW-1:0]),
    .wdata_i(div_digit),
    .re_i   (ram_re),
    .raddr_i(idx_q),
    .rdata_o(ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Sequencer and output register
  // --------------------------------------------------------------------------
  logic                out_valid_q, out_valid_d;
  logic [CHAR_W-1:0]   out_char_q, out_char_d;
  logic [COUNT_W-1:0]  out_count_q, out_count_d;
  logic                out_last_q, out_last_d;
  logic                out_bad_q, out_bad_d;
  logic                slot_free;
  logic [COUNT_W-1:0]  total;

  assign slot_free = ~out_valid_q | m_axis_tready_i;
  assign total     = COUNT_W'(cnt_q) + COUNT_W'(neg_q);

  assign s_axis_tready_o = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    neg_d       = neg_q;
    div_start   = 1'b0;
    div_operand = in_mag;
    out_valid_d = out_valid_q & ~m_axis_tready_i;
    out_char_d  = out_char_q;
    out_count_d = out_count_q;
    out_last_d  = out_last_q;
    out_bad_d   = out_bad_q;

    unique case (state_q)
      S_IDLE: begin
        if (s_hs) begin
          neg_d = in_neg;
          cnt_d = '0;
          if (in_bad) begin
            state_d = S_BAD;
          end else begin
            div_start = 1'b1;
            state_d   = S_DIVIDE;
          end
        end
      end
      S_BAD: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_char_d  = '0;
          out_count_d = '0;
          out_last_d  = 1'b1;
          out_bad_d   = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_DIVIDE: begin
        if (div_st.done) begin
          cnt_d = cnt_q + 1'b1;
          idx_d = cnt_q[AddrW-1:0];
          if (div_st.nonzero) begin
            // keep dividing the quotient
            div_start   = 1'b1;
            div_operand = div_quot;
          end else if (neg_q) begin
            state_d = S_SIGN;
          end else begin
            state_d = S_FETCH;
          end
        end
      end
      S_SIGN: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_char_d  = MINUS_CHAR;
          out_last_d  = (total == COUNT_W'(1));
          out_count_d = (total == COUNT_W'(1)) ? total : '0;
          out_bad_d   = 1'b0;
          state_d     = S_FETCH;
        end
      end
      S_FETCH: begin
        state_d = S_SHOW;  // read data lands next cycle
      end
      S_SHOW: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_char_d  = symbol_of(ram_rdata, chars_lo_q, chars_hi_q);
          out_last_d  = (idx_q == '0);
          out_count_d = (idx_q == '0) ? total : '0;
          out_bad_d   = 1'b0;
          if (idx_q == '0) begin
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_q - 1'b1;
            state_d = S_FETCH;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      idx_q       <= '0;
      neg_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_char_q  <= '0;
      out_count_q <= '0;
      out_last_q  <= 1'b0;
      out_bad_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      neg_q       <= neg_d;
      out_valid_q <= out_valid_d;
      out_char_q  <= out_char_d;
      out_count_q <= out_count_d;
      out_last_q  <= out_last_d;
      out_bad_q   <= out_bad_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_count_q, out_char_q};
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = out_bad_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `RNF_ASSERT_NEXT(a_accept_busy, s_hs, !s_axis_tready_o, "accepted request did not start work")
  `RNF_ASSERT(a_bad_is_single, !out_valid_q || !out_bad_q || (out_last_q && out_count_q == '0), "bad value result malformed")
  `RNF_ASSERT(a_last_has_count, !out_valid_q || !out_last_q || out_bad_q || out_count_q != '0, "last char without count")
  `RNF_ASSERT(a_div_done_state, !div_st.done || state_q == S_DIVIDE, "divider finished outside divide state")

endmodule
